// File: src/mtds_pkg.sv
// mtds_pkg: shared types, field widths, codes and defaults of the timer scheduler
// no dependencies; compile first
`default_nettype none

package mtds_pkg;

   // fixed field widths of the request and response channels
   localparam int KIND_W = 2;
   localparam int TIME_W = 48;
   localparam int MASK_W = 16;
   localparam int IDX_W  = 4;

   // default sizing
   localparam int NUM_SLOTS_DEF  = 16;
   localparam int TIME_BITS_DEF  = 48;
   localparam int MAX_ROUNDS_DEF = 64;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD     = 2'd0,
      KIND_CLEAR   = 2'd1,
      KIND_ADVANCE = 2'd2,
      KIND_NOP     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              periodic;
      logic [TIME_W-1:0] first_deadline;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] target_time;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] fire_time;
      logic [MASK_W-1:0] fired_mask;
      logic [TIME_W-1:0] latest_fire;
      logic [TIME_W-1:0] earliest_deadline;
      logic [IDX_W-1:0]  slot_index;
      logic              table_full;
      logic              overrun;
      logic              last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic fire;
      logic emit;
      logic last;
      logic overrun;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic due;
      logic out_free;
   } sts_type;

   // cycles from a slot update until the registered minimum reflects it
   function automatic int tree_latency(input int num_slots);
      return $clog2(num_slots) + 1;
   endfunction

endpackage

`default_nettype wire

// File: src/mtds_ifs.sv
// mtds_req_if and mtds_rsp_if: valid/ready channels of the timer scheduler
// depends on mtds_pkg for field widths
`default_nettype none

interface mtds_req_if;
   logic                          valid;
   logic                          ready;
   logic [mtds_pkg::KIND_W-1:0]   kind;
   logic                          periodic;
   logic [mtds_pkg::TIME_W-1:0]   first_deadline;
   logic [mtds_pkg::TIME_W-1:0]   period;
   logic [mtds_pkg::TIME_W-1:0]   start_time;
   logic [mtds_pkg::TIME_W-1:0]   target_time;

   modport source (
      output valid, kind, periodic, first_deadline, period, start_time, target_time,
      input  ready
   );
   modport sink (
      input  valid, kind, periodic, first_deadline, period, start_time, target_time,
      output ready
   );
endinterface

interface mtds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mtds_pkg::TIME_W-1:0]   fire_time;
   logic [mtds_pkg::MASK_W-1:0]   fired_mask;
   logic [mtds_pkg::TIME_W-1:0]   latest_fire;
   logic [mtds_pkg::TIME_W-1:0]   earliest_deadline;
   logic [mtds_pkg::IDX_W-1:0]    slot_index;
   logic                          table_full;
   logic                          overrun;
   logic                          last;

   modport source (
      output valid, fire_time, fired_mask, latest_fire, earliest_deadline, slot_index,
             table_full, overrun, last,
      input  ready
   );
   modport sink (
      input  valid, fire_time, fired_mask, latest_fire, earliest_deadline, slot_index,
             table_full, overrun, last,
      output ready
   );
endinterface

`default_nettype wire

// File: src/mtds_ctl.sv
// mtds_ctl: sequencing state machine of the timer scheduler
// depends on mtds_pkg; drives command struct to mtds_datapath
`default_nettype none

module mtds_ctl #(
   parameter int NUM_SLOTS  = mtds_pkg::NUM_SLOTS_DEF,
   parameter int MAX_ROUNDS = mtds_pkg::MAX_ROUNDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [mtds_pkg::KIND_W-1:0] req_kind,
   output logic                        req_ready,
   input  mtds_pkg::sts_type           sts,
   output mtds_pkg::cmd_type           cmd
);

   localparam int TreeLat = mtds_pkg::tree_latency(NUM_SLOTS);
   localparam int WaitW   = $clog2(TreeLat + 1);
   localparam int RoundW  = $clog2(MAX_ROUNDS + 1);
   localparam logic [WaitW-1:0]  WaitLoad = WaitW'(TreeLat - 1);
   localparam logic [RoundW-1:0] RoundMax = RoundW'(MAX_ROUNDS);

   mtds_pkg::state_type state_ff, state_in;
   logic [WaitW-1:0]    wait_ff, wait_in;
   logic [RoundW-1:0]   rounds_ff, rounds_in;
   logic                adv_ff, adv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mtds_pkg::ST_IDLE;
         wait_ff   <= '0;
         rounds_ff <= '0;
         adv_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wait_ff   <= wait_in;
         rounds_ff <= rounds_in;
         adv_ff    <= adv_in;
      end
   end

   always_comb begin
      logic more;
      logic emit_need;
      state_in  = state_ff;
      wait_in   = wait_ff;
      rounds_in = rounds_ff;
      adv_in    = adv_ff;
      req_ready = 1'b0;
      cmd       = '0;
      // during an advance, another round runs when something is due and the round budget remains
      more      = adv_ff && sts.due && (rounds_ff != RoundMax);
      // first evaluation of an advance with something due fires without a result
      emit_need = !(adv_ff && (rounds_ff == '0) && sts.due);
      unique case (state_ff)
         mtds_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               adv_in    = (req_kind == mtds_pkg::KIND_ADVANCE);
               rounds_in = '0;
               wait_in   = WaitLoad;
               state_in  = mtds_pkg::ST_WAIT;
            end
         end
         mtds_pkg::ST_WAIT: begin
            if (wait_ff == '0) begin
               state_in = mtds_pkg::ST_EVAL;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         mtds_pkg::ST_EVAL: begin
            if (!emit_need || sts.out_free) begin
               cmd.emit    = emit_need;
               cmd.last    = !more;
               cmd.overrun = adv_ff && sts.due && (rounds_ff == RoundMax);
               if (more) begin
                  cmd.fire  = 1'b1;
                  rounds_in = rounds_ff + 1'b1;
                  wait_in   = WaitLoad;
                  state_in  = mtds_pkg::ST_WAIT;
               end else begin
                  state_in = mtds_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mtds_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/mtds_datapath.sv
// mtds_datapath: slot table, registered minimum tree, fire logic and response register
// depends on mtds_pkg; commanded by mtds_ctl
`default_nettype none

module mtds_datapath #(
   parameter int NUM_SLOTS = mtds_pkg::NUM_SLOTS_DEF,
   parameter int TIME_BITS = mtds_pkg::TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mtds_pkg::req_type req,
   input  mtds_pkg::cmd_type cmd,
   output mtds_pkg::sts_type sts,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output mtds_pkg::rsp_type rsp
);

   localparam int Levels = $clog2(NUM_SLOTS);
   localparam int Leaves = 1 << Levels;
   localparam int SlotW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int TimeW  = mtds_pkg::TIME_W;
   localparam int MaskW  = mtds_pkg::MASK_W;
   localparam int IdxW   = mtds_pkg::IDX_W;
   localparam logic [TIME_BITS-1:0] Never = {TIME_BITS{1'b1}};

   // slot table
   logic [NUM_SLOTS-1:0] used_ff;
   logic                 periodic_ff [NUM_SLOTS];
   logic [TIME_BITS-1:0] period_ff   [NUM_SLOTS];
   logic [TIME_BITS-1:0] deadline_ff [NUM_SLOTS];

   logic [TIME_BITS-1:0] sched_ff;
   logic [TIME_BITS-1:0] target_ff;
   logic [TIME_BITS-1:0] min_ff;

   // result held for the next emit
   logic [TIME_BITS-1:0] pend_time_ff;
   logic [MaskW-1:0]     pend_mask_ff;
   logic [IdxW-1:0]      pend_idx_ff;
   logic                 pend_full_ff;

   logic                 rsp_valid_ff;
   mtds_pkg::rsp_type    rsp_ff;

   logic [TIME_BITS-1:0] first_t, period_t, start_t, target_t;
   logic [TIME_BITS-1:0] add_last_fire;
   logic [TIME_BITS-1:0] room;
   logic                 is_add, is_clear;
   logic                 free_found;
   logic [SlotW-1:0]     free_idx;
   logic [NUM_SLOTS-1:0] fire_vec;
   logic [TIME_BITS-1:0] next_dl [NUM_SLOTS];
   logic [TIME_BITS-1:0] leaf    [Leaves];
   logic [TIME_BITS-1:0] root;

   assign first_t  = TIME_BITS'(req.first_deadline);
   assign period_t = TIME_BITS'(req.period);
   assign start_t  = TIME_BITS'(req.start_time);
   assign target_t = TIME_BITS'(req.target_time);

   assign is_add   = (req.kind == mtds_pkg::KIND_ADD);
   assign is_clear = (req.kind == mtds_pkg::KIND_CLEAR);

   // periodic timers start as if they had fired one period earlier, floored at zero
   assign add_last_fire = req.periodic ?
                          ((first_t >= period_t) ? first_t - period_t : '0) : start_t;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SlotW'(i);
         end
      end
   end

   // per slot fire test and saturating deadline step
   assign room = Never - min_ff;

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         fire_vec[i] = used_ff[i] && (deadline_ff[i] == min_ff);
         if (periodic_ff[i] && (period_ff[i] < room)) begin
            next_dl[i] = min_ff + period_ff[i];
         end else begin
            next_dl[i] = Never;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (cmd.load && is_add && free_found && (free_idx == SlotW'(i))) begin
            periodic_ff[i] <= req.periodic;
            period_ff[i]   <= period_t;
            deadline_ff[i] <= first_t;
         end else if (cmd.fire && fire_vec[i]) begin
            deadline_ff[i] <= next_dl[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         sched_ff <= '0;
      end else if (cmd.load) begin
         if (is_add && free_found) begin
            used_ff[free_idx] <= 1'b1;
            if (add_last_fire > sched_ff) begin
               sched_ff <= add_last_fire;
            end
         end else if (is_clear) begin
            used_ff  <= '0;
            sched_ff <= Never;
         end
      end else if (cmd.fire && (min_ff > sched_ff)) begin
         sched_ff <= min_ff;
      end
   end

   // pending result and target
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff    <= target_t;
         pend_time_ff <= Never;
         pend_mask_ff <= '0;
         pend_idx_ff  <= (is_add && free_found) ? IdxW'(free_idx) : '0;
         pend_full_ff <= is_add && !free_found;
      end else if (cmd.fire) begin
         pend_time_ff <= min_ff;
         pend_mask_ff <= MaskW'(fire_vec);
         pend_idx_ff  <= '0;
         pend_full_ff <= 1'b0;
      end
   end

   // minimum tree: unused and padding leaves read as never
   for (genvar j = 0; j < Leaves; j++) begin : g_leaf
      if (j < NUM_SLOTS) begin : g_slot
         assign leaf[j] = used_ff[j] ? deadline_ff[j] : Never;
      end else begin : g_pad
         assign leaf[j] = Never;
      end
   end

   if (Leaves == 1) begin : g_flat
      assign root = leaf[0];
   end else begin : g_tree
      logic [TIME_BITS-1:0] tree_ff [1:Leaves-1];
      for (genvar n = 1; n < Leaves; n++) begin : g_node
         logic [TIME_BITS-1:0] lhs;
         logic [TIME_BITS-1:0] rhs;
         if (2 * n >= Leaves) begin : g_bottom
            assign lhs = leaf[2 * n - Leaves];
            assign rhs = leaf[2 * n + 1 - Leaves];
         end else begin : g_inner
            assign lhs = tree_ff[2 * n];
            assign rhs = tree_ff[2 * n + 1];
         end
         always_ff @(posedge clock) begin
            tree_ff[n] <= (rhs < lhs) ? rhs : lhs;
         end
      end
      assign root = tree_ff[1];
   end

   always_ff @(posedge clock) begin
      min_ff <= root;
   end

   assign sts.due      = (min_ff != Never) && (min_ff <= target_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.fire_time         <= TimeW'(pend_time_ff);
         rsp_ff.fired_mask        <= pend_mask_ff;
         rsp_ff.latest_fire       <= TimeW'(sched_ff);
         rsp_ff.earliest_deadline <= TimeW'(min_ff);
         rsp_ff.slot_index        <= pend_idx_ff;
         rsp_ff.table_full        <= pend_full_ff;
         rsp_ff.overrun           <= cmd.overrun;
         rsp_ff.last              <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: src/multi_timer_deadline_scheduler.sv
// response: a request's slot update passes the registered minimum tree and min_ff
//   while the controller waits in ST_WAIT; ST_EVAL then emits into the response
//   register once it is free, and an advance fires and waits again for each round
// one request at a time, the next taken back in ST_IDLE; the wait follows tree depth
// reset: synchronous, clears the slot used flags, the last-fire time and the
//   response valid; no clearing pass, ready again in the first cycle after reset
`default_nettype none

module multi_timer_deadline_scheduler #(
   parameter int NUM_SLOTS  = mtds_pkg::NUM_SLOTS_DEF,
   parameter int TIME_BITS  = mtds_pkg::TIME_BITS_DEF,
   parameter int MAX_ROUNDS = mtds_pkg::MAX_ROUNDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mtds_req_if.sink   req_ch,
   mtds_rsp_if.source rsp_ch
);

   // request payload gathered into one struct for the datapath
   mtds_pkg::req_type req;
   mtds_pkg::rsp_type rsp;
   mtds_pkg::cmd_type cmd;
   mtds_pkg::sts_type sts;
   logic              ready;
   logic              rsp_valid;

   assign req.kind           = req_ch.kind;
   assign req.periodic       = req_ch.periodic;
   assign req.first_deadline = req_ch.first_deadline;
   assign req.period         = req_ch.period;
   assign req.start_time     = req_ch.start_time;
   assign req.target_time    = req_ch.target_time;

   // request transfer happens only while the controller sits idle
   assign req_ch.ready = ready;

   // controller: waits out the tree latency, then emits and/or fires a round
   mtds_ctl #(
      .NUM_SLOTS  (NUM_SLOTS),
      .MAX_ROUNDS (MAX_ROUNDS)
   ) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: slot table, minimum tree, per slot fire lanes, response register
   mtds_datapath #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // response channel straight from the output register
   assign rsp_ch.valid             = rsp_valid;
   assign rsp_ch.fire_time         = rsp.fire_time;
   assign rsp_ch.fired_mask        = rsp.fired_mask;
   assign rsp_ch.latest_fire       = rsp.latest_fire;
   assign rsp_ch.earliest_deadline = rsp.earliest_deadline;
   assign rsp_ch.slot_index        = rsp.slot_index;
   assign rsp_ch.table_full        = rsp.table_full;
   assign rsp_ch.overrun           = rsp.overrun;
   assign rsp_ch.last              = rsp.last;

endmodule

`default_nettype wire

// File: src/mtds_checker.sv
// mtds_checker: port level assertions for the timer scheduler
// depends on mtds_pkg; bound to multi_timer_deadline_scheduler below
`default_nettype none

module mtds_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [mtds_pkg::TIME_W-1:0] fire_time,
   input wire logic [mtds_pkg::MASK_W-1:0] fired_mask,
   input wire logic [mtds_pkg::IDX_W-1:0]  slot_index,
   input wire logic                        table_full,
   input wire logic                        overrun,
   input wire logic                        last
);

   // a stalled response stays valid and keeps its fire time and last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(fire_time) && $stable(last))
      else $error("stalled response changed");

   // one request in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // overrun only on the closing response of an advance
   a_ovr_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overrun |-> last)
      else $error("overrun on a non-final response");

   // add responses with a full table or a nonzero slot index carry no firing
   a_add_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (table_full || slot_index != '0) |->
         last && !overrun && fired_mask == '0 && fire_time == '1)
      else $error("add response carries a firing");

   // reset leaves the block idle with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind multi_timer_deadline_scheduler mtds_checker u_mtds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .fire_time  (rsp_ch.fire_time),
   .fired_mask (rsp_ch.fired_mask),
   .slot_index (rsp_ch.slot_index),
   .table_full (rsp_ch.table_full),
   .overrun    (rsp_ch.overrun),
   .last       (rsp_ch.last)
);

`default_nettype wire

// File: tb/sv/multi_timer_deadline_scheduler_checker.sv
`timescale 1ns / 1ps
// multi_timer_deadline_scheduler_checker: watches both channels, keeps its own timer table
// and compares every response transfer field by field; depends on mtds_pkg and mtds_ifs

module multi_timer_deadline_scheduler_checker (
   input  logic clock,
   input  logic reset,
   mtds_req_if  req_mon,
   mtds_rsp_if  rsp_mon,
   output int   error_count,
   output int   rsp_pending,
   output int   rsp_checked,
   output int   overrun_seen,
   output int   full_seen
);
   import mtds_pkg::*;

   localparam int SLOTS  = NUM_SLOTS_DEF;
   localparam int ROUNDS = MAX_ROUNDS_DEF;
   localparam logic [TIME_W-1:0] NEVER = '1;

   logic              slot_used     [SLOTS];
   logic              slot_periodic [SLOTS];
   logic [TIME_W-1:0] slot_period   [SLOTS];
   logic [TIME_W-1:0] slot_deadline [SLOTS];
   logic [TIME_W-1:0] slot_last_fire[SLOTS];
   logic [TIME_W-1:0] sched_last;

   rsp_type fire_reports[$];

   function automatic logic [TIME_W-1:0] min_deadline();
      logic [TIME_W-1:0] m;
      m = NEVER;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_deadline[i] < m) m = slot_deadline[i];
      return m;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   // stamp the table summary onto a response and queue it
   task automatic queue_report(input rsp_type rec);
      rec.latest_fire       = sched_last;
      rec.earliest_deadline = min_deadline();
      fire_reports = {fire_reports, rec};
   endtask

   task automatic step_timer_table(input req_type r);
      rsp_type           rec;
      int                s;
      int                rounds;
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] room;
      rec = '0;
      rec.fire_time = NEVER;
      rec.last = 1'b1;
      case (r.kind)
         KIND_ADD: begin
            s = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!slot_used[i]) s = i;
            if (s < 0) begin
               rec.table_full = 1'b1;
            end else begin
               slot_used[s]     = 1'b1;
               slot_periodic[s] = r.periodic;
               slot_period[s]   = r.period;
               slot_deadline[s] = r.first_deadline;
               if (r.periodic)
                  slot_last_fire[s] = (r.first_deadline >= r.period) ?
                                      r.first_deadline - r.period : '0;
               else
                  slot_last_fire[s] = r.start_time;
               if (slot_last_fire[s] > sched_last) sched_last = slot_last_fire[s];
               rec.slot_index = s[IDX_W-1:0];
            end
            queue_report(rec);
         end
         KIND_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
            sched_last = NEVER;
            queue_report(rec);
         end
         KIND_ADVANCE: begin
            rounds = 0;
            due = min_deadline();
            while (rounds < ROUNDS && due != NEVER && due <= r.target_time) begin
               rec = '0;
               rec.fire_time = due;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_used[i] && slot_deadline[i] <= due) begin
                     rec.fired_mask[i] = 1'b1;
                     slot_last_fire[i] = due;
                     if (slot_periodic[i]) begin
                        room = NEVER - due;
                        slot_deadline[i] = (slot_period[i] >= room) ? NEVER
                                                                     : due + slot_period[i];
                     end else begin
                        slot_deadline[i] = NEVER;
                     end
                  end
               end
               if (sched_last < due) sched_last = due;
               queue_report(rec);
               rounds++;
               due = min_deadline();
            end
            if (rounds == 0) begin
               queue_report(rec);
            end else begin
               rec = fire_reports.pop_back();
               rec.last = 1'b1;
               rec.overrun = (rounds == ROUNDS) && due != NEVER && due <= r.target_time;
               fire_reports = {fire_reports, rec};
            end
         end
         default: queue_report(rec);
      endcase
   endtask

   task automatic check_response();
      rsp_type want;
      if (fire_reports.size() == 0) begin
         report_mismatch("response with nothing pending, fire_time", rsp_mon.fire_time, 0);
         return;
      end
      want = fire_reports.pop_front();
      rsp_checked++;
      if (want.overrun) overrun_seen++;
      if (want.table_full) full_seen++;
      if (rsp_mon.fire_time !== want.fire_time)
         report_mismatch("fire_time", rsp_mon.fire_time, want.fire_time);
      if (rsp_mon.fired_mask !== want.fired_mask)
         report_mismatch("fired_mask", rsp_mon.fired_mask, want.fired_mask);
      if (rsp_mon.latest_fire !== want.latest_fire)
         report_mismatch("latest_fire", rsp_mon.latest_fire, want.latest_fire);
      if (rsp_mon.earliest_deadline !== want.earliest_deadline)
         report_mismatch("earliest_deadline", rsp_mon.earliest_deadline,
                         want.earliest_deadline);
      if (rsp_mon.slot_index !== want.slot_index)
         report_mismatch("slot_index", rsp_mon.slot_index, want.slot_index);
      if (rsp_mon.table_full !== want.table_full)
         report_mismatch("table_full", rsp_mon.table_full, want.table_full);
      if (rsp_mon.overrun !== want.overrun)
         report_mismatch("overrun", rsp_mon.overrun, want.overrun);
      if (rsp_mon.last !== want.last)
         report_mismatch("last", rsp_mon.last, want.last);
   endtask

   always @(posedge clock) begin
      req_type r;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
         sched_last = '0;
         fire_reports.delete();
         error_count  = 0;
         rsp_checked  = 0;
         overrun_seen = 0;
         full_seen    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_response();
         if (req_mon.valid && req_mon.ready) begin
            r.kind           = req_mon.kind;
            r.periodic       = req_mon.periodic;
            r.first_deadline = req_mon.first_deadline;
            r.period         = req_mon.period;
            r.start_time     = req_mon.start_time;
            r.target_time    = req_mon.target_time;
            step_timer_table(r);
         end
      end
      rsp_pending <= fire_reports.size();
   end

endmodule

// File: tb/sv/multi_timer_deadline_scheduler_test.sv
`timescale 1ns / 1ps
// multi_timer_deadline_scheduler_test: stimulus and verdict for the timer scheduler
// depends on mtds_pkg, mtds_ifs, the block and multi_timer_deadline_scheduler_checker

module multi_timer_deadline_scheduler_test;
   import mtds_pkg::*;

   localparam int RANDOM_ITEMS = 96;
   localparam int WATCHDOG     = 5000;  // cycles without any transfer
   localparam int DRAIN        = 24;    // quiet cycles after the last response
   localparam logic [TIME_W-1:0] TIME_MAX = {{(TIME_W-1){1'b1}}, 1'b0};

   logic clock;
   logic reset;

   mtds_req_if req_if ();
   mtds_rsp_if rsp_if ();

   int error_count;
   int rsp_pending;
   int rsp_checked;
   int overrun_seen;
   int full_seen;

   int   reqs_sent;
   logic src_free;       // sender runs back to back while set
   logic sink_free;      // receiver starts no new stalls while set
   int   stall_left;
   int   sink_cycles;
   int   idle_cycles;

   multi_timer_deadline_scheduler u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   multi_timer_deadline_scheduler_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .error_count  (error_count),
      .rsp_pending  (rsp_pending),
      .rsp_checked  (rsp_checked),
      .overrun_seen (overrun_seen),
      .full_seen    (full_seen)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // full-range time, never the all-ones value
   function automatic logic [TIME_W-1:0] wide_time();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if (raw[TIME_W-1:0] == '1) return TIME_MAX;
      return raw[TIME_W-1:0];
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (src_free) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // unused fields carry random noise so every bit toggles
   function automatic req_type make_plain(input kind_type k);
      req_type r;
      r.kind           = k;
      r.periodic       = 1'($urandom_range(0, 1));
      r.first_deadline = wide_time();
      r.period         = wide_time();
      r.start_time     = wide_time();
      r.target_time    = wide_time();
      return r;
   endfunction

   function automatic req_type make_add(input logic per, input logic [TIME_W-1:0] first,
                                        input logic [TIME_W-1:0] per_len,
                                        input logic [TIME_W-1:0] start);
      req_type r;
      r = make_plain(KIND_ADD);
      r.periodic       = per;
      r.first_deadline = first;
      r.period         = per_len;
      r.start_time     = start;
      return r;
   endfunction

   function automatic req_type make_advance(input logic [TIME_W-1:0] target);
      req_type r;
      r = make_plain(KIND_ADVANCE);
      r.target_time = target;
      return r;
   endfunction

   // hold valid until the transfer; valid stays up when no gap follows
   task automatic send_req(input req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.kind           <= r.kind;
      req_if.periodic       <= r.periodic;
      req_if.first_deadline <= r.first_deadline;
      req_if.period         <= r.period;
      req_if.start_time     <= r.start_time;
      req_if.target_time    <= r.target_time;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      reqs_sent++;
   endtask

   // response ready: random stalls, some long, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
         sink_free    <= 1'b0;
         sink_cycles  <= 0;
      end else begin
         sink_cycles <= sink_cycles + 1;
         if (sink_cycles % 300 == 0) sink_free <= ($urandom_range(0, 3) == 0);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!sink_free && $urandom_range(0, 99) < 30)
               stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("watchdog: no transfer for %0d cycles, %0d responses pending",
                  idle_cycles, rsp_pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] first;
      logic [TIME_W-1:0] per_len;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] target;
      int                pick;
      int                roll;
      int                directed_count;

      reqs_sent = 0;
      src_free  = 1'b0;
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.kind           <= KIND_NOP;
      req_if.periodic       <= 1'b0;
      req_if.first_deadline <= '0;
      req_if.period         <= '0;
      req_if.start_time     <= '0;
      req_if.target_time    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_req(make_advance('0));                          // empty table, nothing due
      send_req(make_plain(KIND_NOP));                      // no-op kind
      send_req(make_add(1'b0, 48'd10, wide_time(), 48'd5));
      send_req(make_add(1'b1, 48'd5, 48'd10, wide_time())); // last fire saturates at zero
      send_req(make_add(1'b1, 48'd100, 48'd30, wide_time()));
      send_req(make_advance(48'd50));
      send_req(make_add(1'b1, 48'd200, 48'd0, wide_time())); // zero period
      send_req(make_advance(48'd300));                     // runs into the round limit
      for (int i = 0; i < 12; i++)                          // fill the rest of the table
         send_req(make_add(1'b0, (i == 0) ? '0 : 48'd1000 + 48'(i), wide_time(),
                           (i == 0) ? '0 : wide_time()));
      send_req(make_add(1'b1, 48'd1, 48'd1, 48'd0));       // table full
      send_req(make_plain(KIND_CLEAR));                    // last fire becomes never
      send_req(make_add(1'b1, TIME_MAX, TIME_MAX, 48'd0)); // next deadline overflows
      send_req(make_advance(TIME_MAX));
      send_req(make_advance(TIME_MAX));                    // never deadline does not fire
      directed_count = reqs_sent;

      // random part: adds near the running time, advances across them
      now = '0;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 20 == 0) src_free = ($urandom_range(0, 3) == 0);
         if (now > TIME_MAX - 48'd10000) now = 48'($urandom_range(0, 1000));
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            roll = $urandom_range(0, 99);
            first = (roll < 85) ? now + 48'($urandom_range(0, 300)) :
                    (roll < 95) ? wide_time() : TIME_MAX;
            roll = $urandom_range(0, 99);
            per_len = (roll < 80) ? 48'($urandom_range(5, 120)) :
                      (roll < 90) ? 48'($urandom_range(1, 4)) : wide_time();
            if (per_len == '0) per_len = 48'd1;
            start = $urandom_range(0, 1) ? now - 48'($urandom_range(0, 50)) : wide_time();
            send_req(make_add(1'($urandom_range(0, 1)), first, per_len, start));
         end else if (pick < 85) begin
            roll = $urandom_range(0, 99);
            target = (roll < 85) ? now + 48'($urandom_range(0, 400)) :
                     (roll < 95) ? wide_time() : TIME_MAX;
            now = target;
            send_req(make_advance(target));
         end else if (pick < 93) begin
            send_req(make_plain(KIND_CLEAR));
         end else begin
            send_req(make_plain(KIND_NOP));
         end
      end
      req_if.valid <= 1'b0;

      // let the checker see the last request, then drain
      @(posedge clock);
      while (rsp_pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("covered %0d requests (%0d directed), %0d responses compared",
               reqs_sent, directed_count, rsp_checked);
      $display("advances hitting the round limit: %0d, adds into a full table: %0d",
               overrun_seen, full_seen);
      if (error_count == 0 && rsp_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: multi_timer_deadline_scheduler.f
src/mtds_pkg.sv
src/mtds_ifs.sv
src/mtds_ctl.sv
src/mtds_datapath.sv
src/multi_timer_deadline_scheduler.sv
src/mtds_checker.sv
tb/sv/multi_timer_deadline_scheduler_checker.sv
tb/sv/multi_timer_deadline_scheduler_test.sv
